// ----- rtl/sfr_pkg.sv -----
// shared types and constants for the sampled frame receiver
// no dependencies; imported by sfr_core and sampled_frame_receiver
package sfr_pkg;

  localparam int FrameBitsDefault = 34;
  localparam int IndexWidth       = 6;
  localparam int WordWidth        = 32;
  localparam int CountWidth       = 8;

  localparam logic [CountWidth-1:0] CountMax   = 8'hff;
  localparam logic [CountWidth-1:0] LimitReset = 8'd5;

  // register map, index = byte address / 4
  localparam logic RegInvertLine = 1'b0;
  localparam logic RegErrorLimit = 1'b1;

  // kind of an input transfer
  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoEdge   = 2'd1,
    StatusBadFrame = 2'd2,
    StatusParity   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [WordWidth-1:0]    frame_word;
    logic [CountWidth-1:0]   error_total;
    logic                    resync_needed;
  } result_t;

  typedef struct packed {
    logic                  invert_line;
    logic [CountWidth-1:0] error_limit;
  } config_t;

endpackage

// ----- rtl/sampled_frame_receiver.sv -----
// sampled frame receiver: input register, step logic, then result register; throughput
// one input transfer per cycle while the result register is empty or m_axis_tready high;
// the step logic between input and result register sets this
// rst (synchronous, active high) clears frame state, error count, valid flags and
// configuration (invert_line 0, error_limit 5)
// top level; depends on sfr_pkg and sfr_core
module sampled_frame_receiver import sfr_pkg::*; #(
  parameter int FRAME_BITS = FrameBitsDefault
) (
  input  logic        clk,
  input  logic        rst,

  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] line_level, [1] edge_seen, [7:2] zero
  input  logic        s_axis_tuser,   // [0] req_type

  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] frame_word, [34:32] message_type, [42:35] data_identifier,
  // [58:43] data_value, [66:59] error_total, [67] resync_needed, [71:68] zero
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] status

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  config_t cfg;
  logic    cfg_write;

  // input register
  logic in_valid;
  logic in_req_type;
  logic in_line_level;
  logic in_edge_seen;

  // result register
  logic    out_valid;
  result_t out_res;

  logic    advance;
  logic    res_valid;
  result_t res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_line <= 1'b0;
      cfg.error_limit <= LimitReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        RegInvertLine: cfg.invert_line <= pwdata[0];
        RegErrorLimit: cfg.error_limit <= pwdata[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegInvertLine: prdata = {31'd0, cfg.invert_line};
      RegErrorLimit: prdata = {{(32-CountWidth){1'b0}}, cfg.error_limit};
      default:       prdata = '0;
    endcase
  end

  // pipeline moves when the result register is empty or being drained
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_type   <= s_axis_tuser;
      in_line_level <= s_axis_tdata[0];
      in_edge_seen  <= s_axis_tdata[1];
    end
  end

  // one step per held sample, taken when the result side can absorb it
  sfr_core #(
    .FRAME_BITS(FRAME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_valid && advance),
    .req_type  (in_req_type),
    .line_level(in_line_level),
    .edge_seen (in_edge_seen),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  // message fields are slices of the frame word, zero when it is
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {4'd0,
                          out_res.resync_needed,
                          out_res.error_total,
                          out_res.frame_word[15:0],
                          out_res.frame_word[23:16],
                          out_res.frame_word[30:28],
                          out_res.frame_word};

endmodule

// ----- rtl/sfr_core.sv -----
// frame decoding state and per-sample step logic
// depends on sfr_pkg
module sfr_core import sfr_pkg::*; #(
  parameter int FRAME_BITS = FrameBitsDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    req_type,
  input  logic    line_level,
  input  logic    edge_seen,
  input  config_t cfg,
  output logic    res_valid,
  output result_t res
);

  localparam logic [IndexWidth-1:0] LastIdx = IndexWidth'(FRAME_BITS - 1);
  localparam logic [IndexWidth-1:0] EndIdx  = IndexWidth'(FRAME_BITS);

  logic [IndexWidth-1:0] bit_index, bit_index_next;
  logic [WordWidth-1:0]  shift_word, shift_word_next;
  logic                  parity_odd, parity_odd_next;
  logic [CountWidth-1:0] error_count, error_count_next;
  logic                  receiving, receiving_next;

  logic                  sample;
  logic [CountWidth-1:0] count_up;
  logic [CountWidth-1:0] count_down;
  logic                  fail;
  status_t               fail_status;

  assign sample     = line_level ^ cfg.invert_line;
  assign count_up   = (error_count == CountMax) ? CountMax : error_count + 1'b1;
  assign count_down = (error_count == '0) ? '0 : error_count - 1'b1;

  always_comb begin
    bit_index_next   = bit_index;
    shift_word_next  = shift_word;
    parity_odd_next  = parity_odd;
    error_count_next = error_count;
    receiving_next   = receiving;
    res_valid        = 1'b0;
    fail             = 1'b0;
    fail_status      = StatusOk;
    res.status        = StatusOk;
    res.frame_word    = shift_word;
    res.error_total   = count_down;
    res.resync_needed = 1'b0;

    if (step) begin
      if (req_type == ReqStart) begin
        bit_index_next  = '0;
        shift_word_next = '0;
        parity_odd_next = 1'b0;
        receiving_next  = 1'b1;
      end else if (receiving) begin
        if (bit_index < EndIdx) begin
          if (bit_index != '0 && !edge_seen) begin
            fail        = 1'b1;
            fail_status = StatusNoEdge;
          end else if ((bit_index == '0 || bit_index == LastIdx) && !sample) begin
            fail        = 1'b1;
            fail_status = StatusBadFrame;
          end else begin
            parity_odd_next = parity_odd ^ sample;
            if (bit_index != '0 && bit_index != LastIdx) begin
              shift_word_next = {shift_word[WordWidth-2:0], sample};
            end
            bit_index_next = bit_index + 1'b1;
          end
        end else if (parity_odd) begin
          fail        = 1'b1;
          fail_status = StatusParity;
        end else begin
          error_count_next = count_down;
          receiving_next   = 1'b0;
          res_valid        = 1'b1;
        end

        if (fail) begin
          error_count_next  = count_up;
          receiving_next    = 1'b0;
          res_valid         = 1'b1;
          res.status        = fail_status;
          res.frame_word    = '0;
          res.error_total   = count_up;
          res.resync_needed = (count_up >= cfg.error_limit);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index   <= '0;
      shift_word  <= '0;
      parity_odd  <= 1'b0;
      error_count <= '0;
      receiving   <= 1'b0;
    end else begin
      bit_index   <= bit_index_next;
      shift_word  <= shift_word_next;
      parity_odd  <= parity_odd_next;
      error_count <= error_count_next;
      receiving   <= receiving_next;
    end
  end

endmodule
